>>> rtl/core/fixed_block_pool_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication on clk, masked while rst is high.
`define FBPA_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("fbpa: same-cycle check failed");

// Next-cycle implication on clk, masked while rst is high.
`define FBPA_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("fbpa: next-cycle check failed");

`endif

>>> rtl/core/fbpa_pkg.sv
// Package of widths, codes and defaults for the block pool allocator.
`default_nettype none
package fbpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int CNT_W     = 9;
  localparam int IDX_OUT_W = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_BLOCKS = 256;

  localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'd0;
  localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 13'd512;
  localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = 9'd256;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_BAD   = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_BLOCK_COUNT = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

>>> rtl/core/fbpa_div.sv
// Restoring divider, one quotient bit per cycle, for address-to-block conversion.
`default_nettype none
module fbpa_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output logic                            done,
  output logic [fbpa_pkg::ADDR_W-1:0]     quotient,
  output logic [fbpa_pkg::SIZE_W-1:0]     remainder
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   diff;
  logic              fits;

  assign rem_sh = {remainder, quotient[ADDR_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(ADDR_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      remainder <= fits ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      quotient  <= {quotient[ADDR_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator.
// Usage:
// Requests arrive on the s_ stream: tuser selects allocate (0) or release (1),
// tdata carries the address to release. Each request gives exactly one
// response on the m_ stream: tuser is the status (ok, pool empty, not
// allocated), tdata holds the block address and, above it, the block id.
// The pool is to be set through cfg_we, cfg_index and cfg_data only while no
// request is outstanding; the block itself does not enforce this. One request
// is handled at a time. An allocate passes through the multiply, add and
// result states, after a queue read state first when the id comes from the
// return queue; an allocate on an empty pool goes straight to the result state.
// A release runs the bit-serial divider that turns the byte offset into a block
// id, then checks the in-use memory and answers; a misaligned or out-of-range
// address skips the check, and a zero block_size skips the divider as well.
// s_tready is high again in the cycle in which the response appears. After
// reset the in-use memory is swept clear, one entry a cycle through all
// MAX_BLOCKS entries, and s_tready stays low meanwhile; configuration writes
// are taken throughout. A response waits in the output register while m_tready
// is low, and the next request is still taken and worked on; it holds its own
// response until the register is free.
`default_nettype none
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]     cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // address
  input  wire logic [fbpa_pkg::ADDR_W-1:0]     s_tdata,
  // kind
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // block_address [31:0], block_index [39:32]
  output logic [fbpa_pkg::ADDR_W+fbpa_pkg::IDX_OUT_W-1:0] m_tdata,
  // status
  output logic [fbpa_pkg::STATUS_W-1:0]        m_tuser
);
  import fbpa_pkg::*;
  `include "fixed_block_pool_allocator_macros.svh"

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int PW = IW + SIZE_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_CHK, ST_QRD, ST_MUL, ST_ADD, ST_RES
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  block_count;

  logic [CW-1:0]     fresh;
  logic [IW-1:0]     queue_head;
  logic [IW-1:0]     queue_tail;
  logic [CW-1:0]     queue_count;
  logic [IW-1:0]     clr_idx;
  logic [CW-1:0]     count_eff;

  logic [IW-1:0]     id;
  logic [PW-1:0]     prod;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [IW-1:0]     res_id;

  logic              in_use_mem [MAX_BLOCKS];
  logic [IW-1:0]     rq_mem [MAX_BLOCKS];
  logic              iu_rdata;
  logic [IW-1:0]     rq_rdata;
  logic              iu_we;
  logic [IW-1:0]     iu_waddr;
  logic              iu_wdata;
  logic              rq_we;

  logic              take;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [SIZE_W-1:0] div_rem;
  logic              div_ok;

  assign count_eff = (32'(block_count) < 32'(MAX_BLOCKS)) ? CW'(block_count) : CW'(MAX_BLOCKS);
  assign s_tready  = (state == ST_IDLE);
  assign take      = s_tvalid && s_tready;
  assign div_start = take && (s_tuser == KIND_RELEASE) && (block_size != '0);
  assign div_ok    = (div_rem == '0) && (div_quo < 32'(count_eff));

  fbpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (s_tdata - pool_base),
    .divisor   (block_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= RST_POOL_BASE;
      block_size  <= RST_BLOCK_SIZE;
      block_count <= RST_BLOCK_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE:   pool_base   <= cfg_data;
        REG_BLOCK_SIZE:  block_size  <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    iu_we    = 1'b0;
    iu_waddr = id;
    iu_wdata = 1'b0;
    rq_we    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        iu_we    = 1'b1;
        iu_waddr = clr_idx;
      end
      ST_MUL: begin
        iu_we    = 1'b1;
        iu_wdata = 1'b1;
      end
      ST_CHK: begin
        iu_we = iu_rdata;
        rq_we = iu_rdata && (queue_count < CW'(MAX_BLOCKS));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (iu_we) begin
      in_use_mem[iu_waddr] <= iu_wdata;
    end
    iu_rdata <= in_use_mem[div_quo[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rq_we) begin
      rq_mem[queue_tail] <= id;
    end
    rq_rdata <= rq_mem[queue_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      fresh       <= '0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_RES)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(MAX_BLOCKS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            res_status <= (s_tuser == KIND_ALLOC) ? STATUS_EMPTY : STATUS_BAD;
            res_addr   <= '0;
            res_id     <= '0;
            if (s_tuser == KIND_ALLOC) begin
              if (fresh < count_eff) begin
                id    <= fresh[IW-1:0];
                fresh <= fresh + 1'b1;
                state <= ST_MUL;
              end else if (queue_count != '0) begin
                queue_head  <= (queue_head == IW'(MAX_BLOCKS - 1)) ? '0 : queue_head + 1'b1;
                queue_count <= queue_count - 1'b1;
                state       <= ST_QRD;
              end else begin
                state <= ST_RES;
              end
            end else if (block_size == '0) begin
              state <= ST_RES;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            id    <= div_quo[IW-1:0];
            state <= div_ok ? ST_CHK : ST_RES;
          end
        end
        ST_CHK: begin
          if (iu_rdata) begin
            res_status <= STATUS_OK;
            res_id     <= id;
            if (rq_we) begin
              queue_tail  <= (queue_tail == IW'(MAX_BLOCKS - 1)) ? '0 : queue_tail + 1'b1;
              queue_count <= queue_count + 1'b1;
            end
          end
          state <= ST_RES;
        end
        ST_QRD: begin
          id    <= rq_rdata;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= PW'(id) * PW'(block_size);
          state <= ST_ADD;
        end
        ST_ADD: begin
          res_status <= STATUS_OK;
          res_addr   <= pool_base + ADDR_W'(prod);
          res_id     <= id;
          state      <= ST_RES;
        end
        ST_RES: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {IDX_OUT_W'(res_id), res_addr};
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `FBPA_ASSERT_IMP(a_err_fields_zero, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0)
  `FBPA_ASSERT_IMP(a_div_done_in_div, div_done, state == ST_DIV)
  `FBPA_ASSERT_NXT(a_one_item_at_once, take, !s_tready)
  `FBPA_ASSERT_IMP(a_queue_bound, s_tready, queue_count <= CW'(MAX_BLOCKS))

endmodule
`default_nettype wire
